>>> rtl/i2cbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cbs_pkg;

	localparam logic [7:0] ACK_TIMEOUT = 8'd250;

	typedef enum logic [2:0] {
		FUNC_START = 3'd0,
		FUNC_STOP  = 3'd1,
		FUNC_SEND  = 3'd2,
		FUNC_WAIT  = 3'd3,
		FUNC_READ  = 3'd4
	} func_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_A    = 5'd1,
		PH_ST_B    = 5'd2,
		PH_ST_FIN  = 5'd3,
		PH_SP_A    = 5'd4,
		PH_SP_B    = 5'd5,
		PH_FIN     = 5'd6,
		PH_TX_A    = 5'd7,
		PH_TX_B    = 5'd8,
		PH_TX_C    = 5'd9,
		PH_RX_A    = 5'd10,
		PH_RX_B    = 5'd11,
		PH_AK_A    = 5'd12,
		PH_AK_B    = 5'd13,
		PH_RX_FIN  = 5'd14,
		PH_WA_A    = 5'd15,
		PH_WA_B    = 5'd16,
		PH_WA_POLL = 5'd17
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} i2cbs_in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} i2cbs_out_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] delay_count;
		logic [3:0] bit_count;
		logic [7:0] shift_reg;
		logic [7:0] poll_count;
		logic       ack_choice;
		logic       scl;
		logic       sda;
		logic       drv;
		logic       fail_flag;
		logic [7:0] rx_byte;
	} i2cbs_state_t;

	// idle, counters clear, SCL and SDA high and driven
	localparam i2cbs_state_t STATE_RESET = '{
		phase:       PH_IDLE,
		delay_count: 3'd0,
		bit_count:   4'd0,
		shift_reg:   8'd0,
		poll_count:  8'd0,
		ack_choice:  1'b0,
		scl:         1'b1,
		sda:         1'b1,
		drv:         1'b1,
		fail_flag:   1'b0,
		rx_byte:     8'd0
	};

endpackage

>>> rtl/i2cbs_step.sv
// One-tick next-state and result logic of the bit sequencer.
`timescale 1ns / 1ps

module i2cbs_step import i2cbs_pkg::*; (
	input  i2cbs_state_t cur,
	input  i2cbs_in_t    item,
	output i2cbs_state_t nxt,
	output i2cbs_out_t   res
);

	function automatic logic [2:0] hold_len(input phase_t p);
		unique case (p)
			PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: hold_len = 3'd4;
			PH_TX_A, PH_TX_B, PH_TX_C, PH_RX_A, PH_AK_A, PH_AK_B: hold_len = 3'd2;
			default: hold_len = 3'd1;
		endcase
	endfunction

	always_comb begin
		i2cbs_state_t s;
		logic         done;
		s    = cur;
		done = 1'b0;

		// take a command only when idle
		if (s.phase == PH_IDLE && item.cmd_valid) begin
			s.delay_count = '0;
			unique case (item.func)
				FUNC_START: s.phase = PH_ST_A;
				FUNC_STOP:  s.phase = PH_SP_A;
				FUNC_SEND: begin
					s.shift_reg = item.tx_byte;
					s.bit_count = '0;
					s.phase     = PH_TX_A;
				end
				FUNC_WAIT: begin
					s.poll_count = '0;
					s.phase      = PH_WA_A;
				end
				FUNC_READ: begin
					s.ack_choice = item.send_ack;
					s.shift_reg  = '0;
					s.bit_count  = '0;
					s.phase      = PH_RX_A;
				end
				default: ;
			endcase
		end

		if (s.phase == PH_WA_POLL) begin
			if (!item.sda_in) begin
				s.scl       = 1'b0;
				s.fail_flag = 1'b0;
				done        = 1'b1;
				s.phase     = PH_IDLE;
			end else if (s.poll_count >= ACK_TIMEOUT) begin
				// timed out: flag and launch the stop timeline on this tick
				s.fail_flag   = 1'b1;
				s.phase       = PH_SP_A;
				s.drv         = 1'b1;
				s.scl         = 1'b0;
				s.sda         = 1'b0;
				s.delay_count = 3'd1;
			end else begin
				s.poll_count = s.poll_count + 8'd1;
			end
		end else if (s.phase != PH_IDLE) begin
			if (s.delay_count == '0) begin
				unique case (s.phase)
					PH_ST_A: begin
						s.drv = 1'b1; s.sda = 1'b1; s.scl = 1'b1;
					end
					PH_ST_B:   s.sda = 1'b0;
					PH_ST_FIN: begin
						s.scl = 1'b0; done = 1'b1;
					end
					PH_SP_A: begin
						s.drv = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
					end
					PH_SP_B: begin
						s.scl = 1'b1; s.sda = 1'b1;
					end
					PH_FIN:    done = 1'b1;
					PH_TX_A: begin
						s.drv       = 1'b1;
						s.scl       = 1'b0;
						s.sda       = s.shift_reg[7];
						s.shift_reg = {s.shift_reg[6:0], 1'b0};
					end
					PH_TX_B:   s.scl = 1'b1;
					PH_TX_C:   s.scl = 1'b0;
					PH_RX_A: begin
						s.drv = 1'b0; s.scl = 1'b0;
					end
					PH_RX_B: begin
						s.scl       = 1'b1;
						s.shift_reg = {s.shift_reg[6:0], item.sda_in};
					end
					PH_AK_A: begin
						s.drv = 1'b1; s.scl = 1'b0; s.sda = ~s.ack_choice;
					end
					PH_AK_B:   s.scl = 1'b1;
					PH_RX_FIN: begin
						s.scl = 1'b0; s.rx_byte = s.shift_reg; done = 1'b1;
					end
					PH_WA_A: begin
						s.drv = 1'b0; s.sda = 1'b1;
					end
					PH_WA_B:   s.scl = 1'b1;
					default: ;
				endcase
			end
			s.delay_count = s.delay_count + 3'd1;
			if (s.delay_count >= hold_len(s.phase)) begin
				s.delay_count = '0;
				unique case (s.phase)
					PH_ST_A: s.phase = PH_ST_B;
					PH_ST_B: s.phase = PH_ST_FIN;
					PH_SP_A: s.phase = PH_SP_B;
					PH_SP_B: s.phase = PH_FIN;
					PH_TX_A: s.phase = PH_TX_B;
					PH_TX_B: s.phase = PH_TX_C;
					PH_TX_C: begin
						s.bit_count = s.bit_count + 4'd1;
						s.phase     = (s.bit_count >= 4'd8) ? PH_FIN : PH_TX_A;
					end
					PH_RX_A: s.phase = PH_RX_B;
					PH_RX_B: begin
						s.bit_count = s.bit_count + 4'd1;
						s.phase     = (s.bit_count >= 4'd8) ? PH_AK_A : PH_RX_A;
					end
					PH_AK_A: s.phase = PH_AK_B;
					PH_AK_B: s.phase = PH_RX_FIN;
					PH_WA_A: s.phase = PH_WA_B;
					PH_WA_B: s.phase = PH_WA_POLL;
					default: s.phase = PH_IDLE;
				endcase
			end
		end

		nxt            = s;
		res.scl_level  = s.scl;
		res.sda_level  = s.sda;
		res.sda_drive  = s.drv;
		res.busy_res   = (s.phase != PH_IDLE);
		res.done_res   = done;
		res.rx_byte    = s.rx_byte;
		res.ack_failed = s.fail_flag;
	end

endmodule

>>> rtl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: input stage, state and result register.
`timescale 1ns / 1ps
//
// Usage: feed one request per bus tick on the input channel (in_valid /
// in_ready / in_item). Each request carries the sampled SDA level and, if
// cmd_valid is set while the sequencer is idle, a command (start, stop,
// send byte, wait for acknowledge, read byte). Every request yields exactly
// one result on the output channel (out_valid / out_ready / out_item) with
// the SCL, SDA and SDA direction levels to drive after that tick, plus
// busy, done, the last received byte and the acknowledge failure flag.
// Path: a request is registered in the input register on acceptance, and
// its result is loaded into the result register once the output is free.
// Throughput: one request per cycle while the output is not stalled, set by
// the combinational step logic between the input register and the result register.
// Reset: SCL and SDA high and driven, idle, all counters and flags clear,
// no result pending.
// Stall: when out_ready is low the pending result holds and the input
// register keeps one request, so in_ready drops only while both are full.
//
module i2c_master_bit_sequencer_core import i2cbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  i2cbs_in_t  in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output i2cbs_out_t out_item
);

	i2cbs_in_t    item_s1;
	logic         valid_s1;
	i2cbs_state_t state_q;
	i2cbs_state_t state_nxt;
	i2cbs_out_t   res;
	i2cbs_out_t   out_item_q;
	logic         out_valid_q;
	logic         advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	i2cbs_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load a new result only when the old one is gone
	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> rtl/i2cbs_checker.sv
// Port-level checks for the I2C master bit sequencer, bound to the top level.
`timescale 1ns / 1ps

module i2cbs_checker import i2cbs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input i2cbs_in_t  in_item,
	input logic       out_valid,
	input logic       out_ready,
	input i2cbs_out_t out_item
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// a finishing tick is never also busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> !out_item.busy_res)
		else $error("done and busy set together");

	// drop input ready only under output backpressure
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// hold a waiting request steady until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("waiting request changed or dropped");

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_i2cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
